### rtl/ist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the integer set table: field widths, op
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  // Field widths
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 32;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;  // op + value, padded to whole bytes
  localparam int OUT_TDATA_W = 16;  // result fields, padded to whole bytes

  // Op codes; the unused code behaves as a query
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;     // latch request, clear scan state
    logic scan;        // walk the held slots
    logic append;      // write key at slot count, increment count
    logic refuse;      // flag a refused add
    logic fetch_last;  // read the last held slot
    logic move;        // write last entry into the hole, decrement count
    logic load_out;    // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic op_add;
    logic op_remove;
    logic full;
    logic out_free;
  } ctrl_sts_t;

endpackage

### rtl/ist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer of the integer set table: takes one request, runs the scan,
// picks the update and hands the result to the output register.
// ----------------------------------------------------------------------------
module ist_ctrl
  import ist_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.op_remove && sts.found) begin
          state_next = ST_MOVE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MOVE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        // Hold off requests while reset is applied
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.append     = sts.op_add && !sts.found && !sts.full;
        cmd.refuse     = sts.op_add && !sts.found && sts.full;
        cmd.fetch_last = sts.op_remove && sts.found;
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/ist_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_datapath
// Entry memory, held count, scan pointer with compare, and the result
// register of the integer set table.
// ----------------------------------------------------------------------------
module ist_datapath
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output ctrl_sts_t              sts,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data;

  logic [OP_W-1:0]           op_r;
  logic signed [VALUE_W-1:0] key;
  logic [CW-1:0]             count;
  logic [CW-1:0]             cnt_m1;
  logic [CW-1:0]             idx;
  logic                      cmp_vld;
  logic [IW-1:0]             cmp_idx;
  logic                      found;
  logic [IW-1:0]             where;
  logic                      refused;

  logic                      hit_now;
  logic                      issue;
  logic                      we;
  logic [IW-1:0]             wa;
  logic [VALUE_W-1:0]        wd;
  logic [IW-1:0]             ra;
  logic [IW+SLOT_W-1:0]      slot_ext;
  logic [CW+COUNT_W-1:0]     count_ext;

  assign cnt_m1  = count - CW'(1);
  assign hit_now = cmd.scan && cmp_vld && (rd_data == key);
  assign issue   = cmd.scan && (idx < count) && !hit_now;

  assign we = cmd.append || cmd.move;
  assign wa = cmd.append ? count[IW-1:0] : where;
  assign wd = cmd.append ? key : rd_data;
  assign ra = cmd.fetch_last ? cnt_m1[IW-1:0] : idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // Request and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_data[OP_W-1:0];
      key  <= in_data[OP_W+VALUE_W-1:OP_W];
    end
    cmp_idx <= idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
      where   <= '0;
      refused <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx     <= '0;
        cmp_vld <= 1'b0;
        found   <= 1'b0;
        where   <= '0;
        refused <= 1'b0;
      end else begin
        cmp_vld <= issue;
        if (issue) begin
          idx <= idx + CW'(1);
        end
        if (hit_now) begin
          found <= 1'b1;
          where <= cmp_idx;
        end
        if (cmd.refuse) begin
          refused <= 1'b1;
        end
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.move) begin
        count <= cnt_m1;
      end
    end
  end

  // Result register
  assign slot_ext  = {{SLOT_W{1'b0}}, where};
  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {{(OUT_TDATA_W - 2 - SLOT_W - COUNT_W){1'b0}},
                   count_ext[COUNT_W-1:0], refused, slot_ext[SLOT_W-1:0], found};
    end
  end

  always_comb begin
    sts.scan_done = hit_now || (idx >= count);
    sts.found     = found;
    sts.op_add    = (op_r == OP_ADD);
    sts.op_remove = (op_r == OP_REMOVE);
    sts.full      = (count == CW'(CAPACITY));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

### rtl/integer_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_table
// Unordered set of distinct 32-bit values kept in a table with a live count.
// A request beat is taken only when idle, then the scan, the decision, a
//   move for a remove that hits, and the result load follow in that order;
//   the next request is taken only once the result is loaded. The scan
//   reads one entry per cycle from the table memory.
// Reset clears the count and the handshake state; table contents stay as
//   they are and are read only after being written.
// ----------------------------------------------------------------------------
module integer_set_table
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
)
(
  input  logic                   clk,
  input  logic                   rst,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op[1:0], value[33:2], zero pad
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // was_present[0], slot[4:1],
                                                 // full_refused[5], count[10:6],
                                                 // zero pad
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer: accepts a beat only when idle, then steps scan, update and
  // result hand-off. The result register lets the next request come in
  // while the previous result is still waiting on the sink.
  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table memory, count, scan compare and result register
  ist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### rtl/ist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks of the integer set table, bound to the top level.
// ----------------------------------------------------------------------------
module ist_checker
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
)
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  // One request in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // A refused add never reports a held value
  a_refuse_absent: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5]) |-> !m_axis_tdata[0])
    else $error("refused add reported the value as present");

  // Absent values report slot zero
  a_absent_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == '0))
    else $error("absent value reported a nonzero slot");

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((CAPACITY > 31) || (int'(m_axis_tdata[10:6]) <= CAPACITY)))
    else $error("count above capacity");

endmodule

bind integer_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);
